// File: hw/rtl/wft_pkg.sv
// Shared types and constants for the whitespace field tokenizer.
// Item and token payload structs, scan mode encoding, register indexes.
// No dependencies; imported by wft_scan and the top level.
package wft_pkg;

  // Input item: one source byte or the end-of-source marker
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  // Result item: one token
  typedef struct packed {
    logic [1:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] end_offset;
    logic [31:0] row_index;
    logic [15:0] column_index;
    logic        last_of_run;
  } token_t;

  // Item commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Token kinds
  localparam logic [1:0] KIND_FIELD   = 2'd0;
  localparam logic [1:0] KIND_MISSING = 2'd1;
  localparam logic [1:0] KIND_EOF     = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_SKIP_EMPTY     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMENT_LEN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMENT_PREFIX = 2'd2;

  // Configuration register contents
  typedef struct packed {
    logic        skip_empty_rows;
    logic [2:0]  comment_length;
    logic [31:0] comment_prefix;
  } cfg_t;

  // Bytes held in the prefix register
  localparam int PREFIX_BYTES = 4;

  // Tokens one item can cause at most
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = 2;
  localparam int RES_CNT_W   = 3;

  // Scanner state
  typedef enum logic [3:0] {
    MODE_LINE  = 4'b0001,
    MODE_BLANK = 4'b0010,
    MODE_FIELD = 4'b0100,
    MODE_SKIP  = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t mode;
    logic       pending_cr;
    logic       skip_bumps_row;
  } scan_ctrl_t;

  // Character codes
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) || (b == CHAR_FF);
  endfunction

  function automatic logic is_break(input logic [7:0] b);
    return (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

endpackage

// File: hw/rtl/wft_scan.sv
// Combinational scan of one item: held lookahead bytes plus the new item.
// Produces the next scanner state and up to four tokens.
// Depends on wft_pkg.
module wft_scan #(
  parameter int OFFSET_BITS       = 32,
  parameter int COLUMN_BITS       = 16,
  parameter int MAX_COMMENT_BYTES = 4,
  localparam int CNT_W            = $clog2(MAX_COMMENT_BYTES + 1)
) (
  input  wft_pkg::cfg_t                                   cfg,
  input  wft_pkg::item_t                                  item,
  input  logic [OFFSET_BITS-1:0]                          byte_offset,
  input  logic [OFFSET_BITS-1:0]                          field_start,
  input  logic [31:0]                                     row_count,
  input  logic [COLUMN_BITS-1:0]                          column_count,
  input  wft_pkg::scan_ctrl_t                             ctrl,
  input  logic [MAX_COMMENT_BYTES-1:0][7:0]               lookahead_bytes,
  input  logic [CNT_W-1:0]                                lookahead_count,
  output logic [OFFSET_BITS-1:0]                          byte_offset_next,
  output logic [OFFSET_BITS-1:0]                          field_start_next,
  output logic [31:0]                                     row_count_next,
  output logic [COLUMN_BITS-1:0]                          column_count_next,
  output wft_pkg::scan_ctrl_t                             ctrl_next,
  output logic [MAX_COMMENT_BYTES-1:0][7:0]               lookahead_bytes_next,
  output logic [CNT_W-1:0]                                lookahead_count_next,
  output wft_pkg::token_t [wft_pkg::MAX_RESULTS-1:0]      tokens,
  output logic [wft_pkg::RES_CNT_W-1:0]                   token_count
);
  import wft_pkg::*;

  localparam int QUEUE_W     = 2 * MAX_COMMENT_BYTES;
  localparam int OFF_SUM_W   = OFFSET_BITS + 1;
  localparam int COL_SUM_W   = COLUMN_BITS + 1;
  localparam logic [3:0] MAX_LEN = 4'(MAX_COMMENT_BYTES);

  localparam logic [1:0] MATCH_NONE = 2'd0;
  localparam logic [1:0] MATCH_HIT  = 2'd1;
  localparam logic [1:0] MATCH_WAIT = 2'd2;

  // Queue of bytes to scan, padded so prefix look-ups never run off the end
  logic [QUEUE_W-1:0][7:0]               q_byte;
  logic [QUEUE_W-1:0]                    q_end;
  logic [QUEUE_W-1:0]                    q_live;
  logic [MAX_COMMENT_BYTES-1:0][7:0]     pfx;
  logic [3:0]                            match_len;
  logic [MAX_COMMENT_BYTES-1:0][1:0]     match;

  // Offsets, rows and columns a few steps ahead, saturating
  logic [MAX_COMMENT_BYTES:0][OFFSET_BITS-1:0] off_at;
  logic [MAX_COMMENT_BYTES:0][31:0]            row_at;
  logic [MAX_COMMENT_BYTES:0][COLUMN_BITS-1:0] col_at;

  // Narrow scan results
  scan_mode_t                         mode;
  logic                               pcr;
  logic                               bumps;
  logic                               stop;
  logic                               ended;
  logic [CNT_W-1:0]                   adv;
  logic [CNT_W-1:0]                   rowd;
  logic [CNT_W-1:0]                   cold;
  logic                               crst;
  logic                               fs_new;
  logic [CNT_W-1:0]                   fs_pos;
  logic [CNT_W-1:0]                   la_n;
  logic [MAX_COMMENT_BYTES-1:0][7:0]  la_b;
  logic [RES_CNT_W-1:0]               ntok;

  // Token descriptors, resolved to full values afterwards
  logic [MAX_RESULTS-1:0][1:0]        t_kind;
  logic [MAX_RESULTS-1:0]             t_sreg;
  logic [MAX_RESULTS-1:0][CNT_W-1:0]  t_spos;
  logic [MAX_RESULTS-1:0][CNT_W-1:0]  t_epos;
  logic [MAX_RESULTS-1:0][CNT_W-1:0]  t_rowd;
  logic [MAX_RESULTS-1:0]             t_crst;
  logic [MAX_RESULTS-1:0][CNT_W-1:0]  t_cold;

  // Prefix bytes; those past the register read as zero
  for (genvar k = 0; k < MAX_COMMENT_BYTES; k++) begin : g_pfx
    if (k < PREFIX_BYTES) begin : g_reg
      assign pfx[k] = cfg.comment_prefix[8*k +: 8];
    end else begin : g_zero
      assign pfx[k] = 8'h00;
    end
  end

  assign match_len = ({1'b0, cfg.comment_length} > MAX_LEN) ? MAX_LEN
                                                            : {1'b0, cfg.comment_length};

  // Saturating look-ahead values
  for (genvar k = 0; k <= MAX_COMMENT_BYTES; k++) begin : g_at
    logic [OFF_SUM_W-1:0] off_sum;
    logic [32:0]          row_sum;
    logic [COL_SUM_W-1:0] col_sum;
    assign off_sum   = {1'b0, byte_offset} + OFF_SUM_W'(k);
    assign row_sum   = {1'b0, row_count} + 33'(k);
    assign col_sum   = {1'b0, column_count} + COL_SUM_W'(k);
    assign off_at[k] = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
    assign row_at[k] = row_sum[32] ? '1 : row_sum[31:0];
    assign col_at[k] = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
  end

  // Build the byte queue: held bytes first, then the new item
  always_comb begin
    for (int k = 0; k < QUEUE_W; k++) begin
      q_live[k] = (k <= int'(lookahead_count));
      q_end[k]  = (k == int'(lookahead_count)) && (item.cmd == CMD_END);
      q_byte[k] = item.data_byte;
    end
    for (int k = 0; k < MAX_COMMENT_BYTES; k++) begin
      if (k < int'(lookahead_count)) begin
        q_byte[k] = lookahead_bytes[k];
      end
    end
  end

  // Comment prefix check at each of the first MAX_COMMENT_BYTES queue positions
  always_comb begin
    for (int i = 0; i < MAX_COMMENT_BYTES; i++) begin
      match[i] = MATCH_NONE;
      if (match_len != 4'd0) begin
        match[i] = MATCH_HIT;
        for (int k = 0; k < MAX_COMMENT_BYTES; k++) begin
          if ((4'(k) < match_len) && (match[i] == MATCH_HIT)) begin
            if (!q_live[i+k]) begin
              match[i] = MATCH_WAIT;
            end else if (q_end[i+k] || (q_byte[i+k] != pfx[k])) begin
              match[i] = MATCH_NONE;
            end
          end
        end
      end
    end
  end

  // Walk the queue one byte per step
  always_comb begin
    logic [7:0]      b;
    logic            go;
    logic            blank;
    logic            brk;
    logic            line_done;
    logic            col_inc;
    logic [1:0]      em;
    logic [1:0][1:0] em_kind;

    mode   = ctrl.mode;
    pcr    = ctrl.pending_cr;
    bumps  = ctrl.skip_bumps_row;
    stop   = 1'b0;
    ended  = 1'b0;
    adv    = '0;
    rowd   = '0;
    cold   = '0;
    crst   = 1'b0;
    fs_new = 1'b0;
    fs_pos = '0;
    la_n   = '0;
    la_b   = '0;
    ntok   = '0;
    t_kind = '0;
    t_sreg = '0;
    t_spos = '0;
    t_epos = '0;
    t_rowd = '0;
    t_crst = '0;
    t_cold = '0;

    for (int i = 0; i < MAX_COMMENT_BYTES; i++) begin
      b         = q_byte[i];
      go        = 1'b0;
      blank     = is_blank(b);
      brk       = is_break(b);
      line_done = 1'b0;
      col_inc   = 1'b0;
      em        = '0;
      em_kind   = '0;

      if (q_live[i] && !stop && !ended) begin
        if (q_end[i]) begin
          // close any open blank run or field, then end of file
          if (mode == MODE_BLANK) begin
            em[0]      = 1'b1;
            em_kind[0] = KIND_MISSING;
          end else if (mode == MODE_FIELD) begin
            em[0]      = 1'b1;
            em_kind[0] = KIND_FIELD;
          end
          em[1]      = 1'b1;
          em_kind[1] = KIND_EOF;
        end else begin
          go = 1'b1;
          // LF straight after a CR break is swallowed
          if (pcr) begin
            pcr = 1'b0;
            if (b == CHAR_LF) begin
              adv = adv + CNT_W'(1);
              go  = 1'b0;
            end
          end
          // comment check at line start or at the first byte after blanks
          if (go && ((mode == MODE_LINE) || ((mode == MODE_BLANK) && !blank))) begin
            if (match[i] == MATCH_WAIT) begin
              stop = 1'b1;
              go   = 1'b0;
              la_n = lookahead_count + CNT_W'(1) - CNT_W'(i);
              for (int j = 0; j < MAX_COMMENT_BYTES; j++) begin
                la_b[j] = q_byte[i+j];
              end
            end else if (match[i] == MATCH_HIT) begin
              bumps = (mode == MODE_BLANK);
              mode  = MODE_SKIP;
            end
          end
          if (go) begin
            case (mode)
              MODE_LINE: begin
                if (brk && cfg.skip_empty_rows) begin
                  pcr = (b == CHAR_CR);
                end else if (blank) begin
                  mode = MODE_BLANK;
                end else if (brk) begin
                  em[0]      = 1'b1;
                  em_kind[0] = KIND_MISSING;
                  line_done  = 1'b1;
                end else begin
                  fs_new = 1'b1;
                  fs_pos = adv;
                  mode   = MODE_FIELD;
                end
              end
              MODE_BLANK: begin
                if (brk) begin
                  em[0]      = 1'b1;
                  em_kind[0] = KIND_MISSING;
                  line_done  = 1'b1;
                end else if (!blank) begin
                  fs_new = 1'b1;
                  fs_pos = adv;
                  mode   = MODE_FIELD;
                end
              end
              MODE_FIELD: begin
                if (blank) begin
                  em[0]      = 1'b1;
                  em_kind[0] = KIND_FIELD;
                  col_inc    = 1'b1;
                  mode       = MODE_BLANK;
                end else if (brk) begin
                  em[0]      = 1'b1;
                  em_kind[0] = KIND_FIELD;
                  line_done  = 1'b1;
                end
              end
              default: begin
                // comment skip runs to the next break
                if (brk) begin
                  if (bumps) begin
                    line_done = 1'b1;
                  end else begin
                    crst = 1'b1;
                    cold = '0;
                    pcr  = (b == CHAR_CR);
                    mode = MODE_LINE;
                  end
                  bumps = 1'b0;
                end
              end
            endcase
          end
        end

        // record tokens with the position before this byte's updates
        for (int r = 0; r < 2; r++) begin
          if (em[r]) begin
            for (int t = 0; t < MAX_RESULTS; t++) begin
              if (ntok == RES_CNT_W'(t)) begin
                t_kind[t] = em_kind[r];
                t_sreg[t] = !fs_new;
                t_spos[t] = fs_pos;
                t_epos[t] = adv;
                t_rowd[t] = rowd;
                t_crst[t] = crst;
                t_cold[t] = cold;
              end
            end
            if (ntok < RES_CNT_W'(MAX_RESULTS)) begin
              ntok = ntok + RES_CNT_W'(1);
            end
          end
        end

        if (q_end[i]) begin
          ended = 1'b1;
        end
        if (line_done) begin
          rowd = rowd + CNT_W'(1);
          crst = 1'b1;
          cold = '0;
          pcr  = (b == CHAR_CR);
          mode = MODE_LINE;
        end
        if (col_inc) begin
          cold = cold + CNT_W'(1);
        end
        if (go) begin
          adv = adv + CNT_W'(1);
        end
      end
    end
  end

  // Resolve tokens to full-width values
  always_comb begin
    for (int t = 0; t < MAX_RESULTS; t++) begin
      tokens[t].token_kind   = t_kind[t];
      tokens[t].start_offset = '0;
      tokens[t].end_offset   = '0;
      tokens[t].row_index    = '0;
      tokens[t].column_index = '0;
      if (t_kind[t] == KIND_FIELD) begin
        tokens[t].start_offset = t_sreg[t] ? 32'(field_start) : 32'(off_at[t_spos[t]]);
        tokens[t].end_offset   = 32'(off_at[t_epos[t]]);
      end
      if (t_kind[t] != KIND_EOF) begin
        tokens[t].row_index    = row_at[t_rowd[t]];
        tokens[t].column_index = t_crst[t] ? 16'(t_cold[t]) : 16'(col_at[t_cold[t]]);
      end
      tokens[t].last_of_run = (RES_CNT_W'(t) == (ntok - RES_CNT_W'(1)));
    end
  end

  assign token_count = ntok;

  // Next scanner state; end of source returns to the reset state
  always_comb begin
    if (ended) begin
      byte_offset_next     = '0;
      field_start_next     = '0;
      row_count_next       = '0;
      column_count_next    = '0;
      ctrl_next.mode       = MODE_LINE;
      ctrl_next.pending_cr = 1'b0;
      ctrl_next.skip_bumps_row = 1'b0;
      lookahead_bytes_next = '0;
      lookahead_count_next = '0;
    end else begin
      byte_offset_next     = off_at[adv];
      field_start_next     = fs_new ? off_at[fs_pos] : field_start;
      row_count_next       = row_at[rowd];
      column_count_next    = crst ? COLUMN_BITS'(cold) : col_at[cold];
      ctrl_next.mode       = mode;
      ctrl_next.pending_cr = pcr;
      ctrl_next.skip_bumps_row = bumps;
      lookahead_bytes_next = la_b;
      lookahead_count_next = la_n;
    end
  end

endmodule

// File: hw/rtl/whitespace_field_tokenizer_core.sv
// Top level of the whitespace field tokenizer: ports, config registers,
// input register, scanner state and the token group buffer.
// Depends on wft_pkg and wft_scan.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-----------------------------------
//   byte     | byte_valid / byte_stall | byte_item  (cmd, data_byte)
//   token    | token_valid/token_stall | token_item (kind, offsets, row...)
//   cfg      | cfg_we                  | cfg_index, cfg_data
//
// One byte per clock while each byte yields at most one token and the token
// side does not stall. A byte yielding several tokens occupies the token group
// buffer until the token port takes its last one, which holds the input for
// that time. A taken byte waits in the input register, then passes the scanner
// into the group buffer once that is free, and its token is offered from there.
// rst is synchronous and returns config and scan state to their reset values.
module whitespace_field_tokenizer_core #(
  parameter int OFFSET_BITS       = 32,
  parameter int MAX_COMMENT_BYTES = 4,
  parameter int COLUMN_BITS       = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 byte_valid,
  output logic                                 byte_stall,
  input  wft_pkg::item_t                       byte_item,
  output logic                                 token_valid,
  input  logic                                 token_stall,
  output wft_pkg::token_t                      token_item,
  input  logic                                 cfg_we,
  input  logic [wft_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wft_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wft_pkg::*;

  localparam int CNT_W = $clog2(MAX_COMMENT_BYTES + 1);

  cfg_t                              cfg;

  // Input register
  logic                              in_full;
  item_t                             in_item;

  // Scanner state
  logic [OFFSET_BITS-1:0]            byte_offset;
  logic [OFFSET_BITS-1:0]            field_start;
  logic [31:0]                       row_count;
  logic [COLUMN_BITS-1:0]            column_count;
  scan_ctrl_t                        ctrl;
  logic [MAX_COMMENT_BYTES-1:0][7:0] lookahead_bytes;
  logic [CNT_W-1:0]                  lookahead_count;

  logic [OFFSET_BITS-1:0]            byte_offset_next;
  logic [OFFSET_BITS-1:0]            field_start_next;
  logic [31:0]                       row_count_next;
  logic [COLUMN_BITS-1:0]            column_count_next;
  scan_ctrl_t                        ctrl_next;
  logic [MAX_COMMENT_BYTES-1:0][7:0] lookahead_bytes_next;
  logic [CNT_W-1:0]                  lookahead_count_next;

  // Token group buffer
  token_t [MAX_RESULTS-1:0]          grp;
  logic [RES_CNT_W-1:0]              grp_count;
  logic [RES_CNT_W-1:0]              rd_ptr;
  token_t [MAX_RESULTS-1:0]          scan_tokens;
  logic [RES_CNT_W-1:0]              scan_count;

  logic                              grp_free;
  logic                              proc;
  logic                              take;
  logic                              accept;

  // Handshakes
  assign token_valid = (rd_ptr != grp_count);
  assign token_item  = grp[rd_ptr[RES_IDX_W-1:0]];
  assign take        = token_valid && !token_stall;
  assign grp_free    = (rd_ptr == grp_count)
                    || (((grp_count - rd_ptr) == RES_CNT_W'(1)) && !token_stall);
  assign proc        = in_full && grp_free;
  assign byte_stall  = in_full && !grp_free;
  assign accept      = byte_valid && !byte_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_empty_rows <= 1'b1;
      cfg.comment_length  <= '0;
      cfg.comment_prefix  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SKIP_EMPTY:     cfg.skip_empty_rows <= cfg_data[0];
        REG_COMMENT_LEN:    cfg.comment_length  <= cfg_data[2:0];
        REG_COMMENT_PREFIX: cfg.comment_prefix  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= byte_item;
    end
  end

  wft_scan #(
    .OFFSET_BITS       (OFFSET_BITS),
    .COLUMN_BITS       (COLUMN_BITS),
    .MAX_COMMENT_BYTES (MAX_COMMENT_BYTES)
  ) u_scan (
    .cfg                  (cfg),
    .item                 (in_item),
    .byte_offset          (byte_offset),
    .field_start          (field_start),
    .row_count            (row_count),
    .column_count         (column_count),
    .ctrl                 (ctrl),
    .lookahead_bytes      (lookahead_bytes),
    .lookahead_count      (lookahead_count),
    .byte_offset_next     (byte_offset_next),
    .field_start_next     (field_start_next),
    .row_count_next       (row_count_next),
    .column_count_next    (column_count_next),
    .ctrl_next            (ctrl_next),
    .lookahead_bytes_next (lookahead_bytes_next),
    .lookahead_count_next (lookahead_count_next),
    .tokens               (scan_tokens),
    .token_count          (scan_count)
  );

  // Scanner state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset         <= '0;
      field_start         <= '0;
      row_count           <= '0;
      column_count        <= '0;
      ctrl.mode           <= MODE_LINE;
      ctrl.pending_cr     <= 1'b0;
      ctrl.skip_bumps_row <= 1'b0;
      lookahead_count     <= '0;
    end else if (proc) begin
      byte_offset     <= byte_offset_next;
      field_start     <= field_start_next;
      row_count       <= row_count_next;
      column_count    <= column_count_next;
      ctrl            <= ctrl_next;
      lookahead_count <= lookahead_count_next;
    end
  end

  // held bytes are only read below the held count
  always_ff @(posedge clk) begin
    if (proc) begin
      lookahead_bytes <= lookahead_bytes_next;
    end
  end

  // Group buffer control: load a fresh group, or step through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_count <= '0;
      rd_ptr    <= '0;
    end else if (proc) begin
      grp_count <= scan_count;
      rd_ptr    <= '0;
    end else if (take) begin
      rd_ptr <= rd_ptr + RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      grp <= scan_tokens;
    end
  end

endmodule

// File: dv/tb_whitespace_field_tokenizer_core.sv
// Self-checking testbench for whitespace_field_tokenizer_core.
// Drives source bytes and end-of-source marks, predicts every token and checks them in order.
// Depends on wft_pkg and the RTL of the tokenizer core only.
`timescale 1ns / 1ps

module tb_whitespace_field_tokenizer_core;
  import wft_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [8:0] END_MARK = 9'h100;

  typedef enum int {LOOK_NONE, LOOK_HIT, LOOK_WAIT} prefix_look_t;
  typedef enum int {
    LINE_EMPTY, LINE_BLANKS, LINE_FIELDS, LINE_COMMENT, LINE_TAIL_COMMENT, LINE_NOISE
  } line_shape_t;
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HEAVY, STALL_BLOCKS} stall_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  item_t byte_item = '0;
  logic token_valid;
  logic token_stall = 1'b0;
  token_t token_item;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  whitespace_field_tokenizer_core DUT (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item(byte_item),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token_item(token_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Source items waiting to go out, tokens waiting to come back
  item_t source_q[$];
  token_t pending_tokens[$];
  token_t step_tokens[$];

  // Register copies
  logic cfg_skip = 1'b1;
  logic [2:0] cfg_len = 3'd0;
  logic [31:0] cfg_prefix = 32'd0;

  // Scanner copy
  logic [31:0] scan_pos = '0;
  logic [31:0] scan_row = '0;
  logic [15:0] scan_col = '0;
  scan_mode_t scan_state = MODE_LINE;
  logic [31:0] field_begin = '0;
  logic [7:0] held_bytes [PREFIX_BYTES];
  int held_count = 0;
  logic cr_seen = 1'b0;
  logic skip_ends_row = 1'b0;

  // Run statistics
  int items_queued = 0;
  int ends_queued = 0;
  int bytes_taken = 0;
  int tokens_checked = 0;
  int fault_count = 0;
  int settings_used = 0;
  int idle_cycles = 0;

  function automatic logic blank_char(logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_VT || b == CHAR_FF;
  endfunction

  function automatic logic break_char(logic [7:0] b);
    return b == CHAR_LF || b == CHAR_CR;
  endfunction

  // Does the comment prefix start at window position i?
  function automatic prefix_look_t look_for_prefix(logic [8:0] win [PREFIX_BYTES+1],
                                                   int win_n, int i);
    int plen;
    int k;
    plen = (cfg_len > PREFIX_BYTES) ? PREFIX_BYTES : int'(cfg_len);
    if (plen == 0) return LOOK_NONE;
    for (k = 0; k < plen; k++) begin
      if (i + k >= win_n) return LOOK_WAIT;
      if (win[i+k] == END_MARK) return LOOK_NONE;
      if (win[i+k][7:0] != cfg_prefix[8*k +: 8]) return LOOK_NONE;
    end
    return LOOK_HIT;
  endfunction

  task automatic add_token(logic [1:0] kind, logic [31:0] s, logic [31:0] e,
                           logic [31:0] r, logic [15:0] c);
    token_t t;
    if (step_tokens.size() < MAX_RESULTS) begin
      t.token_kind = kind;
      t.start_offset = s;
      t.end_offset = e;
      t.row_index = r;
      t.column_index = c;
      t.last_of_run = 1'b0;
      step_tokens.push_back(t);
    end
  endtask

  task automatic bump_pos();
    if (scan_pos != 32'hFFFF_FFFF) scan_pos = scan_pos + 32'd1;
  endtask

  task automatic end_line(logic [7:0] b);
    if (scan_row != 32'hFFFF_FFFF) scan_row = scan_row + 32'd1;
    scan_col = '0;
    cr_seen = (b == CHAR_CR);
    scan_state = MODE_LINE;
  endtask

  task automatic restart_scan();
    int k;
    scan_pos = '0;
    scan_row = '0;
    scan_col = '0;
    scan_state = MODE_LINE;
    field_begin = '0;
    for (k = 0; k < PREFIX_BYTES; k++) held_bytes[k] = '0;
    held_count = 0;
    cr_seen = 1'b0;
    skip_ends_row = 1'b0;
  endtask

  // Work out the tokens one accepted item gives and queue them
  task automatic tokenize_item(item_t it);
    logic [8:0] win [PREFIX_BYTES+1];
    int win_n;
    int i;
    int k;
    logic [8:0] b;
    logic [7:0] c;
    logic stop;
    logic swallow;
    prefix_look_t look;
    token_t t;
    win_n = 0;
    for (k = 0; k < held_count; k++) begin
      win[win_n] = {1'b0, held_bytes[k]};
      win_n++;
    end
    held_count = 0;
    win[win_n] = (it.cmd == CMD_END) ? END_MARK : {1'b0, it.data_byte};
    win_n++;
    step_tokens.delete();
    stop = 1'b0;
    for (i = 0; i < win_n && !stop; i++) begin
      b = win[i];
      c = b[7:0];
      if (b == END_MARK) begin
        // close whatever is open, then end of file
        if (scan_state == MODE_BLANK) add_token(KIND_MISSING, 0, 0, scan_row, scan_col);
        else if (scan_state == MODE_FIELD)
          add_token(KIND_FIELD, field_begin, scan_pos, scan_row, scan_col);
        add_token(KIND_EOF, 0, 0, 0, 0);
        restart_scan();
      end else begin
        swallow = 1'b0;
        if (cr_seen) begin
          cr_seen = 1'b0;
          if (c == CHAR_LF) begin
            bump_pos();
            swallow = 1'b1;
          end
        end
        if (!swallow) begin
          if (scan_state == MODE_LINE || (scan_state == MODE_BLANK && !blank_char(c))) begin
            look = look_for_prefix(win, win_n, i);
            if (look == LOOK_WAIT) begin
              // hold the rest until the prefix can be decided
              for (k = i; k < win_n && held_count < PREFIX_BYTES; k++) begin
                held_bytes[held_count] = win[k][7:0];
                held_count++;
              end
              stop = 1'b1;
            end else if (look == LOOK_HIT) begin
              skip_ends_row = (scan_state == MODE_BLANK);
              scan_state = MODE_SKIP;
            end
          end
          if (!stop) begin
            case (scan_state)
              MODE_LINE: begin
                if (break_char(c) && cfg_skip) begin
                  cr_seen = (c == CHAR_CR);
                end else if (blank_char(c)) begin
                  scan_state = MODE_BLANK;
                end else if (break_char(c)) begin
                  add_token(KIND_MISSING, 0, 0, scan_row, scan_col);
                  end_line(c);
                end else begin
                  field_begin = scan_pos;
                  scan_state = MODE_FIELD;
                end
              end
              MODE_BLANK: begin
                if (break_char(c)) begin
                  add_token(KIND_MISSING, 0, 0, scan_row, scan_col);
                  end_line(c);
                end else if (!blank_char(c)) begin
                  field_begin = scan_pos;
                  scan_state = MODE_FIELD;
                end
              end
              MODE_FIELD: begin
                if (blank_char(c)) begin
                  add_token(KIND_FIELD, field_begin, scan_pos, scan_row, scan_col);
                  if (scan_col != 16'hFFFF) scan_col = scan_col + 16'd1;
                  scan_state = MODE_BLANK;
                end else if (break_char(c)) begin
                  add_token(KIND_FIELD, field_begin, scan_pos, scan_row, scan_col);
                  end_line(c);
                end
              end
              default: begin
                // comment skip runs to the next break
                if (break_char(c)) begin
                  if (skip_ends_row) begin
                    end_line(c);
                  end else begin
                    scan_col = '0;
                    cr_seen = (c == CHAR_CR);
                    scan_state = MODE_LINE;
                  end
                  skip_ends_row = 1'b0;
                end
              end
            endcase
            bump_pos();
          end
        end
      end
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last_of_run = 1'b1;
      step_tokens.push_back(t);
    end
    while (step_tokens.size() > 0) pending_tokens.push_back(step_tokens.pop_front());
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  task automatic push_byte(logic [7:0] b);
    item_t it;
    it.cmd = CMD_BYTE;
    it.data_byte = b;
    source_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_end();
    item_t it;
    it.cmd = CMD_END;
    it.data_byte = 8'($urandom_range(0, 255));
    source_q.push_back(it);
    items_queued++;
    ends_queued++;
  endtask

  task automatic push_blanks(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0: push_byte(CHAR_TAB);
        1: push_byte(CHAR_VT);
        2: push_byte(CHAR_FF);
        default: push_byte(CHAR_SPACE);
      endcase
    end
  endtask

  task automatic push_break();
    case ($urandom_range(0, 2))
      0: push_byte(CHAR_LF);
      1: push_byte(CHAR_CR);
      default: begin
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
      end
    endcase
  endtask

  // Mostly letters, now and then any byte that is neither blank nor break
  task automatic push_field();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 5);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) begin
        b = 8'h61 + 8'($urandom_range(0, 25));
      end else begin
        b = 8'($urandom_range(0, 255));
        while (blank_char(b) || break_char(b)) b = 8'($urandom_range(0, 255));
      end
      push_byte(b);
    end
  endtask

  // Current comment prefix, sometimes with its last byte spoilt
  task automatic push_prefix();
    int k;
    int plen;
    logic spoil;
    plen = (cfg_len == 0) ? 2 : ((cfg_len > PREFIX_BYTES) ? PREFIX_BYTES : int'(cfg_len));
    spoil = ($urandom_range(0, 4) == 0);
    for (k = 0; k < plen; k++) begin
      if (spoil && k == plen - 1) push_byte(cfg_prefix[8*k +: 8] ^ 8'h01);
      else push_byte(cfg_prefix[8*k +: 8]);
    end
  endtask

  task automatic push_line(logic with_break);
    line_shape_t shape;
    int n;
    shape = ($urandom_range(0, 2) == 0) ? LINE_FIELDS : line_shape_t'($urandom_range(0, 5));
    case (shape)
      LINE_EMPTY: ;
      LINE_BLANKS: push_blanks($urandom_range(1, 3));
      LINE_FIELDS: begin
        if ($urandom_range(0, 2) == 0) push_blanks($urandom_range(1, 2));
        n = $urandom_range(1, 4);
        repeat (n) begin
          push_field();
          if (n > 1) push_blanks($urandom_range(1, 2));
          n--;
        end
        if ($urandom_range(0, 4) == 0) push_blanks(1);
      end
      LINE_COMMENT: begin
        push_prefix();
        push_field();
        push_blanks(1);
        push_field();
      end
      LINE_TAIL_COMMENT: begin
        if ($urandom_range(0, 1)) push_field();
        push_blanks($urandom_range(1, 2));
        push_prefix();
        push_field();
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
      end
    endcase
    if (with_break) push_break();
  endtask

  // Random lines with an end of source now and then, closed by an end of source
  task automatic fill_source(int budget);
    int first;
    first = items_queued;
    while (items_queued - first < budget) begin
      push_line(1'b1);
      if ($urandom_range(0, 19) == 0) push_end();
    end
    if ($urandom_range(0, 1)) push_line(1'b0);
    push_end();
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SKIP_EMPTY: cfg_skip = val[0];
      REG_COMMENT_LEN: cfg_len = val[2:0];
      REG_COMMENT_PREFIX: cfg_prefix = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic skip, logic [2:0] len, logic [31:0] prefix);
    write_reg(REG_SKIP_EMPTY, {31'd0, skip});
    write_reg(REG_COMMENT_LEN, {29'd0, len});
    write_reg(REG_COMMENT_PREFIX, prefix);
    settings_used++;
  endtask

  // Wait until every item is taken and every token back, then let the pipe empty
  task automatic settle();
    while (source_q.size() != 0 || byte_valid || pending_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- byte driver

  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        tokenize_item(byte_item);
        bytes_taken++;
      end
      if (byte_valid && byte_stall) begin
        // hold the stalled item
      end else if (gap_left > 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (source_q.size() > 0) begin
        byte_item <= source_q.pop_front();
        byte_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- token monitor

  token_t want_tok;
  stall_style_t stall_style = STALL_NONE;
  int stall_span = 0;

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && token_valid && !token_stall) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: token with none expected, expected nothing, got kind %0d %0h..%0h",
                 $time, token_item.token_kind, token_item.start_offset,
                 token_item.end_offset);
        fault_count++;
      end else begin
        want_tok = pending_tokens.pop_front();
        check_field("token_kind", 32'(want_tok.token_kind), 32'(token_item.token_kind));
        check_field("start_offset", want_tok.start_offset, token_item.start_offset);
        check_field("end_offset", want_tok.end_offset, token_item.end_offset);
        check_field("row_index", want_tok.row_index, token_item.row_index);
        check_field("column_index", 32'(want_tok.column_index),
                    32'(token_item.column_index));
        check_field("last_of_run", 32'(want_tok.last_of_run), 32'(token_item.last_of_run));
        tokens_checked++;
      end
    end
    // receiver back-pressure changes style whenever the current span runs out
    if (stall_span == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_span = $urandom_range(20, 80);
    end else begin
      stall_span--;
    end
    case (stall_style)
      STALL_NONE: token_stall <= 1'b0;
      STALL_SPARSE: token_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: token_stall <= ($urandom_range(0, 3) != 0);
      default: token_stall <= stall_span[2];
    endcase
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((byte_valid && !byte_stall) || (token_valid && !token_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: blanks of every kind, extreme bytes, CR LF, skipped empty lines,
    // end of source after blanks and on its own
    @(negedge clk);
    settings_used++;
    push_byte(CHAR_LF);
    push_byte(CHAR_SPACE);
    push_byte(8'h00);
    push_byte(CHAR_TAB);
    push_byte(8'hFF);
    push_byte(CHAR_VT);
    push_byte(CHAR_FF);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_byte("q");
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    push_byte(CHAR_SPACE);
    push_end();
    push_end();
    settle();

    // Empty line kept, whole-line comment, prefix cut short by the end of source
    apply_setting(1'b0, 3'd2, 32'h0000_2123);
    @(negedge clk);
    push_byte(CHAR_LF);
    push_byte("#");
    push_byte("!");
    push_byte("z");
    push_byte(CHAR_LF);
    push_byte("a");
    push_byte(CHAR_SPACE);
    push_byte("#");
    push_end();
    settle();

    // Random sources over a spread of settings
    apply_setting(1'b0, 3'd0, 32'h0000_0000);
    @(negedge clk);
    fill_source(14);
    settle();

    apply_setting(1'b1, 3'd1, ($urandom & 32'hFFFF_FF00) | 32'h0000_0023);
    @(negedge clk);
    fill_source(14);
    settle();

    apply_setting(1'b0, 3'd4, 32'hFFFF_FFFF);
    @(negedge clk);
    fill_source(14);
    settle();

    // length above the prefix width acts as four bytes
    apply_setting(1'b1, 3'd7, 32'h2D2D_2F2F);
    @(negedge clk);
    fill_source(14);
    settle();

    // prefix with a line feed inside it
    apply_setting(1'b0, 3'd3, {8'h00, 8'h3B, CHAR_LF, 8'h3B});
    @(negedge clk);
    fill_source(14);
    settle();

    // an unused register index must change nothing
    apply_setting(1'b1, 3'd2, $urandom);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    @(negedge clk);
    fill_source(14);
    settle();

    $display("Ran %0d source items (%0d ends of source) under %0d register settings,",
             bytes_taken, ends_queued, settings_used);
    $display("comparing %0d tokens against the prediction.", tokens_checked);
    if (fault_count == 0 && pending_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
